>>> hw/rtl/srrw_pkg.sv
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared constants and codes for the selective-repeat receive window.
// ----------------------------------------------------------------------------
`default_nettype none

package srrw_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int SEG_BYTES = 1000;

  localparam int OFF_W  = 24;
  localparam int NOW_W  = 32;
  localparam int TOUT_W = 16;
  localparam int LEN_W  = 10;
  localparam int CFG_W  = 24;

  // segment index and in-segment remainder widths
  localparam int IDX_W = $clog2(((1 << OFF_W) - 1) / SEG_BYTES + 2);
  localparam int REM_W = $clog2(SEG_BYTES + 1);

  // offset / SEG_BYTES by reciprocal multiply, low by at most one
  localparam int DIV_SH = OFF_W + $clog2(SEG_BYTES + 1);
  localparam int DIV_MW = OFF_W + 1;
  localparam int DIV_PW = 2 * OFF_W + 1;
  localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'((64'd1 << DIV_SH) / SEG_BYTES);

  localparam logic [TOUT_W-1:0] TIMEOUT_RST = TOUT_W'(20);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic OP_SEGMENT = 1'b0;
  localparam logic OP_TIMER   = 1'b1;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/selective_repeat_receive_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receive-window controller: marks arrived segments, delivers the in-order
// run at the head and emits timed-out segment requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item is taken when start is high and busy is low. Opcode
//   segment gives a byte offset; opcode timer gives now_ms for a timeout scan.
//   Results: each result shows on the out_ ports for one cycle with out_strobe
//   high; out_last marks the final result of an item. The receiver cannot
//   stall, so results are simply streamed out.
//   Config: cfg_we writes register cfg_index (0 total_bytes, 1 timeout_ms).
//   Writing total_bytes restarts the window; busy is high while it is set up.
// Sequencing (one item at a time, busy high throughout):
//   segment item: divide, mark the arrival, measure the head run, then
//                 deliver one result per slot of that run.
//   timer item:   an eligibility scan and a due-slot walk, then one pass
//                 over all slots per expired (non-due) request, as the stamp
//                 memory has one read port, read once per slot per pass.
// Reset: window empty, total_bytes 0, timeout_ms 20, no results pending.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receive_window
  import srrw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_opcode,
  input  wire logic [OFF_W-1:0]     in_seg_offset,
  input  wire logic [NOW_W-1:0]     in_now_ms,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output logic                      out_strobe,
  output logic                      out_kind,
  output logic [SLOT_W-1:0]         out_slot,
  output logic [OFF_W-1:0]          out_byte_offset,
  output logic [LEN_W-1:0]          out_length,
  output logic                      out_finished,
  output logic                      out_last
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_MUL, ST_DIV_SUB, ST_DIV_FIX, ST_CFG_SET, ST_ARRIVE,
    ST_DLV_SCAN, ST_DLV_EMIT, ST_TMR_SCAN, ST_TMR_DUE, ST_TMR_SEL, ST_TMR_EMIT
  } state_t;

  state_t              state_r;
  logic [TOUT_W-1:0]   timeout_r;
  logic [IDX_W-1:0]    n_r;
  logic [REM_W-1:0]    tot_rem_r;
  logic [SLOTS-1:0]    recv_r, sched_r, due_r, pend_r;
  logic [IDX_W-1:0]    head_idx_r;
  logic [SLOT_W-1:0]   head_slot_r;

  logic [OFF_W-1:0]    div_x_r;
  logic                div_cfg_r;
  logic [IDX_W-1:0]    div_q_r;
  logic [REM_W:0]      div_rem_r;
  logic [NOW_W-1:0]    now_r;
  logic                fin_r;

  logic [CNT_W-1:0]    cnt_r, k_r, j_r, dcnt_r, pcnt_r;
  logic [IDX_W:0]      scan_end_r;
  logic                p_vld_r;
  logic [SLOT_W-1:0]   p_slot_r;
  logic                best_vld_r;
  logic [SLOT_W-1:0]   best_slot_r;
  logic [NOW_W-1:0]    best_age_r;

  logic                out_strobe_r, out_kind_r, out_fin_r, out_last_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [IDX_W-1:0]    out_idx_r;

  logic [NOW_W-1:0]    stamp_mem [SLOTS];
  logic [NOW_W-1:0]    stamp_rd_r;

  // ---- shared arithmetic ----
  logic [DIV_PW-1:0]   div_prod;
  logic [OFF_W-1:0]    q_times_b;
  logic [IDX_W:0]      n_calc;
  logic [SLOTS-1:0]    init_mask;
  logic [SLOT_W-1:0]   slot_j, scan_slot, arr_slot;
  logic [IDX_W-1:0]    arr_diff;
  logic                arr_ok;
  logic [NOW_W-1:0]    age;
  logic                p_elig;
  logic [CNT_W-1:0]    tot_req;

  assign div_prod  = DIV_PW'(div_x_r) * DIV_PW'(DIV_M);
  assign q_times_b = OFF_W'(OFF_W'(div_q_r) * OFF_W'(SEG_BYTES));
  assign n_calc    = (IDX_W+1)'(div_q_r) + (IDX_W+1)'(div_rem_r != '0);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      init_mask[i] = (IDX_W+1)'(i) < n_calc;
    end
  end

  assign slot_j    = head_slot_r + j_r[SLOT_W-1:0];
  assign scan_slot = head_slot_r + cnt_r[SLOT_W-1:0];
  assign arr_diff  = div_q_r - head_idx_r;
  assign arr_slot  = head_slot_r + arr_diff[SLOT_W-1:0];
  assign arr_ok    = (div_q_r >= head_idx_r) && (div_q_r < n_r) &&
                     (arr_diff < IDX_W'(SLOTS)) && !recv_r[arr_slot];
  assign age       = now_r - stamp_rd_r;
  assign p_elig    = sched_r[p_slot_r] & ~recv_r[p_slot_r];
  assign tot_req   = dcnt_r + pcnt_r;

  // ---- result selection ----
  logic              emit_en, emit_kind, emit_last;
  logic [SLOT_W-1:0] emit_slot;
  logic [SLOT_W-1:0] emit_dist;
  logic [IDX_W-1:0]  emit_idx;

  always_comb begin
    emit_en   = 1'b0;
    emit_kind = KIND_DELIVER;
    emit_slot = head_slot_r;
    emit_last = 1'b0;
    case (state_r)
      ST_DLV_EMIT: begin
        emit_en   = 1'b1;
        emit_last = (k_r == cnt_r - 1'b1);
      end
      ST_TMR_DUE: begin
        emit_en   = sched_r[slot_j] & ~recv_r[slot_j] & due_r[slot_j];
        emit_kind = KIND_REQUEST;
        emit_slot = slot_j;
        emit_last = (k_r == tot_req - 1'b1);
      end
      ST_TMR_EMIT: begin
        emit_en   = 1'b1;
        emit_kind = KIND_REQUEST;
        emit_slot = best_slot_r;
        emit_last = (k_r == tot_req - 1'b1);
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
    emit_dist = emit_slot - head_slot_r;
    emit_idx  = head_idx_r + IDX_W'(emit_dist);
  end

  // ---- stamp memory: restamp on every request, one read per cycle ----
  always_ff @(posedge clk) begin
    if (emit_en && emit_kind == KIND_REQUEST) begin
      stamp_mem[emit_slot] <= now_r;
    end
    stamp_rd_r <= stamp_mem[slot_j];
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      timeout_r    <= TIMEOUT_RST;
      n_r          <= '0;
      tot_rem_r    <= '0;
      recv_r       <= '0;
      sched_r      <= '0;
      due_r        <= '0;
      pend_r       <= '0;
      head_idx_r   <= '0;
      head_slot_r  <= '0;
      div_cfg_r    <= 1'b0;
      p_vld_r      <= 1'b0;
      best_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      k_r          <= '0;
      j_r          <= '0;
      cnt_r        <= '0;
      dcnt_r       <= '0;
      pcnt_r       <= '0;
    end else begin
      out_strobe_r <= emit_en;
      out_kind_r   <= emit_kind;
      out_slot_r   <= emit_slot;
      out_idx_r    <= emit_idx;
      out_fin_r    <= fin_r;
      out_last_r   <= emit_last;
      if (emit_en) begin
        k_r <= k_r + 1'b1;
      end

      p_vld_r  <= (state_r == ST_TMR_SCAN || state_r == ST_TMR_SEL) &&
                  (j_r < CNT_W'(SLOTS));
      p_slot_r <= slot_j;

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            now_r <= in_now_ms;
            fin_r <= head_idx_r >= n_r;
            k_r   <= '0;
            if (in_opcode == OP_SEGMENT) begin
              div_x_r   <= in_seg_offset;
              div_cfg_r <= 1'b0;
              state_r   <= ST_DIV_MUL;
            end else begin
              pend_r  <= '0;
              dcnt_r  <= '0;
              pcnt_r  <= '0;
              j_r     <= '0;
              state_r <= ST_TMR_SCAN;
            end
          end
        end
        ST_DIV_MUL: begin
          div_q_r <= IDX_W'(div_prod >> DIV_SH);
          state_r <= ST_DIV_SUB;
        end
        ST_DIV_SUB: begin
          div_rem_r <= (REM_W+1)'(div_x_r - q_times_b);
          state_r   <= ST_DIV_FIX;
        end
        ST_DIV_FIX: begin
          // reciprocal estimate may be one short
          if (div_rem_r >= (REM_W+1)'(SEG_BYTES)) begin
            div_q_r   <= div_q_r + 1'b1;
            div_rem_r <= div_rem_r - (REM_W+1)'(SEG_BYTES);
          end
          state_r <= div_cfg_r ? ST_CFG_SET : ST_ARRIVE;
        end
        ST_CFG_SET: begin
          n_r         <= IDX_W'(n_calc);
          tot_rem_r   <= REM_W'(div_rem_r);
          recv_r      <= '0;
          sched_r     <= init_mask;
          due_r       <= init_mask;
          head_idx_r  <= '0;
          head_slot_r <= '0;
          state_r     <= ST_IDLE;
        end
        ST_ARRIVE: begin
          if (arr_ok) begin
            recv_r[arr_slot]  <= 1'b1;
            sched_r[arr_slot] <= 1'b0;
            due_r[arr_slot]   <= 1'b0;
          end
          cnt_r      <= '0;
          scan_end_r <= (IDX_W+1)'(head_idx_r);
          state_r    <= ST_DLV_SCAN;
        end
        ST_DLV_SCAN: begin
          // measure the in-order run first so finished and last are known
          if (cnt_r < CNT_W'(SLOTS) && scan_end_r < (IDX_W+1)'(n_r) &&
              recv_r[scan_slot]) begin
            cnt_r      <= cnt_r + 1'b1;
            scan_end_r <= scan_end_r + 1'b1;
          end else if (cnt_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            fin_r   <= scan_end_r >= (IDX_W+1)'(n_r);
            k_r     <= '0;
            state_r <= ST_DLV_EMIT;
          end
        end
        ST_DLV_EMIT: begin
          recv_r[head_slot_r] <= 1'b0;
          if ((IDX_W+1)'(head_idx_r) + (IDX_W+1)'(SLOTS) < (IDX_W+1)'(n_r)) begin
            sched_r[head_slot_r] <= 1'b1;
            due_r[head_slot_r]   <= 1'b1;
          end else begin
            sched_r[head_slot_r] <= 1'b0;
            due_r[head_slot_r]   <= 1'b0;
          end
          head_slot_r <= head_slot_r + 1'b1;
          head_idx_r  <= head_idx_r + 1'b1;
          if (emit_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_TMR_SCAN: begin
          if (j_r < CNT_W'(SLOTS)) begin
            j_r <= j_r + 1'b1;
          end
          if (p_vld_r && p_elig) begin
            if (due_r[p_slot_r]) begin
              dcnt_r <= dcnt_r + 1'b1;
            end else if (age >= NOW_W'(timeout_r)) begin
              pend_r[p_slot_r] <= 1'b1;
              pcnt_r           <= pcnt_r + 1'b1;
            end
          end
          if (j_r == CNT_W'(SLOTS)) begin
            j_r     <= '0;
            state_r <= ST_TMR_DUE;
          end
        end
        ST_TMR_DUE: begin
          if (emit_en) begin
            due_r[slot_j] <= 1'b0;
          end
          if (j_r == CNT_W'(SLOTS - 1)) begin
            j_r        <= '0;
            best_vld_r <= 1'b0;
            state_r    <= (pcnt_r != '0) ? ST_TMR_SEL : ST_IDLE;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        ST_TMR_SEL: begin
          if (j_r < CNT_W'(SLOTS)) begin
            j_r <= j_r + 1'b1;
          end
          // oldest wins, ties keep the earlier slot in window order
          if (p_vld_r && pend_r[p_slot_r] && (!best_vld_r || age > best_age_r)) begin
            best_vld_r  <= 1'b1;
            best_slot_r <= p_slot_r;
            best_age_r  <= age;
          end
          if (j_r == CNT_W'(SLOTS)) begin
            state_r <= ST_TMR_EMIT;
          end
        end
        ST_TMR_EMIT: begin
          pend_r[best_slot_r] <= 1'b0;
          if (emit_last) begin
            state_r <= ST_IDLE;
          end else begin
            j_r        <= '0;
            best_vld_r <= 1'b0;
            state_r    <= ST_TMR_SEL;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (cfg_we) begin
        if (cfg_index == CFG_TOTAL) begin
          div_x_r   <= cfg_wdata[OFF_W-1:0];
          div_cfg_r <= 1'b1;
          state_r   <= ST_DIV_MUL;
        end else if (cfg_index == CFG_TIMEOUT) begin
          timeout_r <= cfg_wdata[TOUT_W-1:0];
        end
      end
    end
  end

  // ---- outputs ----
  logic [REM_W-1:0] len_full;

  always_comb begin
    if ((IDX_W+1)'(out_idx_r) + 1'b1 >= (IDX_W+1)'(n_r) && tot_rem_r != '0) begin
      len_full = tot_rem_r;
    end else begin
      len_full = REM_W'(SEG_BYTES);
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_kind        = out_kind_r;
  assign out_slot        = out_slot_r;
  assign out_byte_offset = OFF_W'(OFF_W'(out_idx_r) * OFF_W'(SEG_BYTES));
  assign out_length      = LEN_W'(len_full);
  assign out_finished    = out_fin_r;
  assign out_last        = out_last_r;

  // ---- assertions ----
  a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r != ST_IDLE))
    else $error("result strobe without an item in progress");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_last_r) |=> !out_strobe_r)
    else $error("result after the last result of an item");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_idx_r <= n_r)
    else $error("head index beyond segment count");

  a_pend_not_due: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & due_r) == '0)
    else $error("slot both pending by age and due at once");

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selective-repeat receive window. It drives
// segment-arrival and timer items through the start/busy port, reprograms
// transfer size and timeout between phases, predicts every delivery and
// request in lock step, and compares each strobed result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import srrw_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  byte_offset;
    logic [LEN_W-1:0]  length;
    logic              finished;
    logic              last;
  } window_result_t;

  typedef struct {
    logic             op;
    logic [OFF_W-1:0] offset;
    logic [NOW_W-1:0] now;
    bit               typed;
    window_result_t   first;
  } directed_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_opcode;
  logic [OFF_W-1:0]     in_seg_offset;
  logic [NOW_W-1:0]     in_now_ms;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 out_strobe;
  logic                 out_kind;
  logic [SLOT_W-1:0]    out_slot;
  logic [OFF_W-1:0]     out_byte_offset;
  logic [LEN_W-1:0]     out_length;
  logic                 out_finished;
  logic                 out_last;

  selective_repeat_receive_window dut (.*);

  // window model state
  bit          rcv_q[SLOTS];
  bit          sched_q[SLOTS];
  bit          due_q[SLOTS];
  logic [31:0] stamp_q[SLOTS];
  int unsigned head_idx;
  int unsigned head_sl;
  int unsigned total_cfg;
  int unsigned tmo_cfg;

  window_result_t pending_results[$];
  int             fail_count;
  int             result_count;
  int             item_count;
  int             cycle_count;
  logic [31:0]    clock_ms;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned seg_total();
    return (total_cfg + SEG_BYTES - 1) / SEG_BYTES;
  endfunction

  function automatic void window_restart();
    int unsigned n;
    n = seg_total();
    for (int i = 0; i < SLOTS; i++) begin
      rcv_q[i] = 1'b0;
      sched_q[i] = (i < n);
      due_q[i] = (i < n);
      stamp_q[i] = '0;
    end
    head_idx = 0;
    head_sl = 0;
  endfunction

  function automatic window_result_t make_result(logic kind, int unsigned s,
                                                 int unsigned idx);
    window_result_t r;
    int unsigned rem;
    rem = total_cfg % SEG_BYTES;
    r.kind = kind;
    r.slot = SLOT_W'(s);
    r.byte_offset = OFF_W'(longint'(idx) * SEG_BYTES);
    r.length = LEN_W'((idx + 1 >= seg_total() && rem != 0) ? rem : SEG_BYTES);
    r.finished = 1'b0;
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the window by one item and append what it should emit.
  function automatic void window_step(logic op, logic [OFF_W-1:0] offset,
                                      logic [NOW_W-1:0] now);
    window_result_t batch[$];
    int unsigned n, idx, s, cnt;
    int          best;
    int unsigned list[SLOTS];
    bit          taken[SLOTS];
    n = seg_total();
    if (op == OP_SEGMENT) begin
      idx = offset / SEG_BYTES;
      if (idx >= head_idx && idx < n && idx - head_idx < SLOTS) begin
        s = (head_sl + idx - head_idx) % SLOTS;
        if (!rcv_q[s]) begin
          rcv_q[s] = 1'b1;
          sched_q[s] = 1'b0;
          due_q[s] = 1'b0;
        end
      end
      while (head_idx < n && rcv_q[head_sl] && batch.size() < SLOTS) begin
        batch.push_back(make_result(KIND_DELIVER, head_sl, head_idx));
        rcv_q[head_sl] = 1'b0;
        sched_q[head_sl] = (longint'(head_idx) + SLOTS < n);
        due_q[head_sl] = sched_q[head_sl];
        head_sl = (head_sl + 1) % SLOTS;
        head_idx++;
      end
    end else begin
      cnt = 0;
      for (int j = 0; j < SLOTS; j++) begin
        s = (head_sl + j) % SLOTS;
        if (sched_q[s] && !rcv_q[s] && (due_q[s] || now - stamp_q[s] >= tmo_cfg)) begin
          list[cnt] = s;
          taken[cnt] = 1'b0;
          cnt++;
        end
      end
      // due slots first, then oldest stamp, ties kept in window order
      for (int j = 0; j < cnt; j++) begin
        best = -1;
        for (int m = 0; m < cnt; m++) begin
          if (taken[m]) continue;
          if (best < 0) best = m;
          else if (!due_q[list[best]] && (due_q[list[m]] ||
                   now - stamp_q[list[m]] > now - stamp_q[list[best]])) best = m;
        end
        taken[best] = 1'b1;
        s = list[best];
        batch.push_back(make_result(KIND_REQUEST, s,
                                    head_idx + (s + SLOTS - head_sl) % SLOTS));
      end
      for (int j = 0; j < cnt; j++) begin
        stamp_q[list[j]] = now;
        due_q[list[j]] = 1'b0;
      end
    end
    foreach (batch[i]) begin
      batch[i].finished = (head_idx >= n);
      batch[i].last = (i == batch.size() - 1);
      pending_results.push_back(batch[i]);
    end
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic hold_idle(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Present one item and hold it until the block takes it.
  task automatic send_item(logic op, logic [OFF_W-1:0] offset,
                           logic [NOW_W-1:0] now, output window_result_t first,
                           output bit has_first);
    int before_cnt;
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_seg_offset = offset;
    in_now_ms = now;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    before_cnt = pending_results.size();
    window_step(op, offset, now);
    has_first = pending_results.size() > before_cnt;
    if (has_first) first = pending_results[before_cnt];
    item_count++;
  endtask

  task automatic drain_and_settle();
    hold_idle(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    drain_and_settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    if (idx == CFG_TOTAL) begin
      total_cfg = data;
      window_restart();
    end else begin
      tmo_cfg = data[TOUT_W-1:0];
    end
    @(negedge clk);
    cfg_we = 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    window_result_t exp_r;
    if (rst_n && out_strobe) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d slot %0d", out_kind, out_slot);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, out_kind);
          fail_count++;
        end
        if (out_slot !== exp_r.slot) begin
          $error("slot: expected %0d, got %0d", exp_r.slot, out_slot);
          fail_count++;
        end
        if (out_byte_offset !== exp_r.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d", exp_r.byte_offset,
                 out_byte_offset);
          fail_count++;
        end
        if (out_length !== exp_r.length) begin
          $error("length: expected %0d, got %0d", exp_r.length, out_length);
          fail_count++;
        end
        if (out_finished !== exp_r.finished) begin
          $error("finished: expected %0d, got %0d", exp_r.finished, out_finished);
          fail_count++;
        end
        if (out_last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL selective_repeat_receive_window");
      $finish;
    end
  end

  function automatic window_result_t typed_result(logic kind, int s, int off,
                                                  int len, logic fin, logic lst);
    window_result_t r;
    r.kind = kind;
    r.slot = SLOT_W'(s);
    r.byte_offset = OFF_W'(off);
    r.length = LEN_W'(len);
    r.finished = fin;
    r.last = lst;
    return r;
  endfunction

  task automatic run_directed(directed_row_t rows[$]);
    window_result_t first;
    bit             has_first;
    foreach (rows[i]) begin
      send_item(rows[i].op, rows[i].offset, rows[i].now, first, has_first);
      if (rows[i].typed && (!has_first || first !== rows[i].first)) begin
        $error("directed row %0d: first result differs from the table", i);
        fail_count++;
      end
      hold_idle(gap_cycles());
    end
  endtask

  task automatic run_random(int count, int seg_share);
    window_result_t first;
    bit             has_first;
    bit             no_gaps;
    logic [OFF_W-1:0] off;
    int unsigned    idx;
    for (int k = 0; k < count; k++) begin
      if (k % 10 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < seg_share) begin
        if ($urandom_range(0, 9) == 0) begin
          off = OFF_W'($urandom);
        end else begin
          // bias toward the head so the run keeps being delivered
          idx = head_idx + (($urandom_range(0, 2) == 0) ? $urandom_range(0, 70)
                                                       : $urandom_range(0, 3));
          off = OFF_W'(longint'(idx) * SEG_BYTES + $urandom_range(0, SEG_BYTES - 1));
        end
        send_item(OP_SEGMENT, off, NOW_W'($urandom), first, has_first);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 2 * tmo_cfg + 2);
        send_item(OP_TIMER, OFF_W'($urandom), clock_ms, first, has_first);
      end
      if (!no_gaps) hold_idle(gap_cycles());
    end
  endtask

  initial begin
    directed_row_t rows[$];
    start = 1'b0;
    in_opcode = OP_SEGMENT;
    in_seg_offset = '0;
    in_now_ms = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TOTAL;
    cfg_wdata = '0;
    fail_count = 0;
    result_count = 0;
    item_count = 0;
    cycle_count = 0;
    total_cfg = 0;
    tmo_cfg = TIMEOUT_RST;
    window_restart();
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty transfer after reset: nothing to deliver or request
    rows = '{
      '{OP_TIMER,   24'd0,        32'd0,          1'b0, '0},
      '{OP_SEGMENT, 24'd0,        32'hFFFF_FFFF,  1'b0, '0}
    };
    run_directed(rows);

    write_reg(CFG_TOTAL, 24'd5500);
    rows = '{
      '{OP_TIMER,   24'd0,        32'd100, 1'b1,
        typed_result(KIND_REQUEST, 0, 0, 1000, 1'b0, 1'b0)},
      '{OP_SEGMENT, 24'd5499,     32'd0,   1'b0, '0},
      '{OP_SEGMENT, 24'd1000,     32'd0,   1'b0, '0},
      '{OP_SEGMENT, 24'd999,      32'd0,   1'b1,
        typed_result(KIND_DELIVER, 0, 0, 1000, 1'b0, 1'b0)},
      '{OP_TIMER,   24'd0,        32'd119, 1'b0, '0},
      '{OP_TIMER,   24'd0,        32'd120, 1'b1,
        typed_result(KIND_REQUEST, 2, 2000, 1000, 1'b0, 1'b0)},
      '{OP_SEGMENT, 24'hFF_FFFF,  32'd0,   1'b0, '0},
      '{OP_SEGMENT, 24'd5000,     32'd0,   1'b0, '0},
      '{OP_SEGMENT, 24'd999,      32'd0,   1'b0, '0},
      '{OP_SEGMENT, 24'd2000,     32'd0,   1'b0, '0},
      '{OP_SEGMENT, 24'd3000,     32'd0,   1'b0, '0},
      '{OP_SEGMENT, 24'd4500,     32'd0,   1'b0, '0},
      '{OP_TIMER,   24'd0,        32'd999, 1'b0, '0},
      '{OP_SEGMENT, 24'd0,        32'd0,   1'b0, '0}
    };
    run_directed(rows);

    // oversized total, zero timeout, timer across the counter wrap
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_TOTAL, 24'hFF_FFFF);
    rows = '{
      '{OP_TIMER,   24'd0,        32'hFFFF_FFFE, 1'b0, '0},
      '{OP_TIMER,   24'd0,        32'h0000_0003, 1'b0, '0},
      '{OP_SEGMENT, 24'd63999,    32'd0,         1'b0, '0},
      '{OP_SEGMENT, 24'd64000,    32'd0,         1'b0, '0},
      '{OP_SEGMENT, 24'd0,        32'd0,         1'b0, '0}
    };
    run_directed(rows);

    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_TOTAL, 24'd70500);
    clock_ms = $urandom;
    run_random(30, 70);

    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_TOTAL, 24'd1);
    run_random(10, 50);

    write_reg(CFG_TIMEOUT, 16'($urandom_range(5, 60)));
    write_reg(CFG_TOTAL, 24'($urandom_range(10000, 140000)));
    clock_ms = $urandom;
    run_random(40, 75);

    write_reg(CFG_TIMEOUT, 16'd20);
    write_reg(CFG_TOTAL, 24'd10000000);
    run_random(25, 60);

    hold_idle(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Ran %0d items through several window sizes and timeouts; %0d results checked.",
             item_count, result_count);
    if (fail_count == 0) begin
      $display("PASS selective_repeat_receive_window");
    end else begin
      $display("FAIL selective_repeat_receive_window");
    end
    $finish;
  end

endmodule

>>> selective_repeat_receive_window.f
hw/rtl/srrw_pkg.sv
hw/rtl/selective_repeat_receive_window.sv
verif/tb.sv
